/* src/sams_pkg.sv */
// ----------------------------------------------------------------------------
// sams_pkg
// Shared types and codes for the shared-array min stacks unit.
// ----------------------------------------------------------------------------
package sams_pkg;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADID = 2'd3;

    localparam logic [1:0] RD_TOP       = 2'd0;
    localparam logic [1:0] RD_SCAN0     = 2'd1;
    localparam logic [1:0] RD_SCAN_NEXT = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       eval;
        logic       push;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       pop_commit;
        logic       scan_start;
        logic       scan_step;
        logic       cap_top;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic       bad_id;
        logic [1:0] mode;
        logic       fill_zero;
        logic       full;
        logic       pop_is_min;
        logic       scan_last;
        logic       out_busy;
    } t_stat;

endpackage

/* src/shared_array_min_stacks_unit.sv */
// ----------------------------------------------------------------------------
// shared_array_min_stacks_unit
// NUM_STACKS min-tracking stacks of signed words in one shared entry memory.
//
//   channel  | valid / ready       | payload
//   ---------+---------------------+--------------------------------------------
//   request  | i_valid / o_ready   | i_mode, i_stack_id, i_data
//   result   | o_valid / i_ready   | o_status, o_popped_value, o_top_value,
//            |                     | o_min_value, o_fill_level
//
// A pop of the minimum rescans the n entries left in its stack, one entry read
// per cycle through the single memory read port.
// One beat is in work at a time; o_ready rises again once its result is loaded.
// Reset clears fill counts and minima at once; no memory clearing pass.
// A stalled result holds in the output register; the next beat may then enter.
// ----------------------------------------------------------------------------
module shared_array_min_stacks_unit #(
    parameter int DEPTH      = 256,
    parameter int NUM_STACKS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_stack_id,
    input  logic signed [31:0] i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_popped_value,
    output logic signed [31:0] o_top_value,
    output logic signed [31:0] o_min_value,
    output logic [8:0]         o_fill_level
);

    sams_pkg::t_cmd  cmd;
    sams_pkg::t_stat stat;

    sams_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sams_datapath #(
        .DEPTH      (DEPTH),
        .NUM_STACKS (NUM_STACKS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_stack_id     (i_stack_id),
        .i_data         (i_data),
        .i_ready        (i_ready),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_min_value    (o_min_value),
        .o_fill_level   (o_fill_level)
    );

endmodule

/* src/sams_datapath.sv */
// ----------------------------------------------------------------------------
// sams_datapath
// Entry memory, per-stack fill counts and minima, scan unit and result register.
// ----------------------------------------------------------------------------
module sams_datapath #(
    parameter int DEPTH      = 256,
    parameter int NUM_STACKS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_mode,
    input  logic [1:0]          i_stack_id,
    input  logic signed [31:0]  i_data,
    input  logic                i_ready,
    input  sams_pkg::t_cmd      i_cmd,
    output sams_pkg::t_stat     o_stat,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_popped_value,
    output logic signed [31:0]  o_top_value,
    output logic signed [31:0]  o_min_value,
    output logic [8:0]          o_fill_level
);

    localparam int FW      = $clog2(DEPTH + 1);
    localparam int ENTRIES = NUM_STACKS * DEPTH;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    logic [1:0]         r_mode;
    logic [1:0]         r_id;
    logic signed [31:0] r_data;
    logic [1:0]         r_status;
    logic [1:0]         n_status;
    logic [FW-1:0]      r_fill [NUM_STACKS];
    logic signed [31:0] r_min  [NUM_STACKS];
    logic signed [31:0] mem    [ENTRIES];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_pop;
    logic signed [31:0] r_top;
    logic signed [31:0] r_smin;
    logic signed [31:0] n_smin;
    logic [FW-1:0]      r_cnt;
    logic               r_valid;

    logic [1:0]         r_out_status;
    logic signed [31:0] r_out_pop;
    logic signed [31:0] r_out_top;
    logic signed [31:0] r_out_min;
    logic [8:0]         r_out_fill;

    logic [SW-1:0]      sidx;
    logic               bad_id;
    logic [FW-1:0]      cur_fill;
    logic [FW-1:0]      fill_dec;
    logic signed [31:0] cur_min;
    logic [AW-1:0]      base;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               full;
    logic               fill_zero;
    logic               scan_last;
    logic [FW+8:0]      fill_ext;

    assign sidx      = SW'(r_id);
    assign bad_id    = 32'(r_id) >= 32'(NUM_STACKS);
    assign cur_fill  = bad_id ? '0 : r_fill[sidx];
    assign cur_min   = bad_id ? 32'sd0 : r_min[sidx];
    assign fill_dec  = cur_fill - FW'(1);
    assign base      = AW'(32'(sidx) * 32'(DEPTH));
    assign wr_addr   = base + AW'(cur_fill);
    assign full      = cur_fill == FW'(DEPTH);
    assign fill_zero = cur_fill == '0;
    assign scan_last = r_cnt == fill_dec;
    assign fill_ext  = {9'b0, cur_fill};

    always_comb begin
        case (i_cmd.rd_sel)
            sams_pkg::RD_TOP:       rd_addr = base + AW'(fill_dec);
            sams_pkg::RD_SCAN0:     rd_addr = base;
            sams_pkg::RD_SCAN_NEXT: rd_addr = base + AW'(r_cnt + FW'(1));
            default:                rd_addr = base;
        endcase
    end

    always_comb begin
        if (bad_id) begin
            n_status = sams_pkg::ST_BADID;
        end else if (r_mode == sams_pkg::MODE_PUSH && full) begin
            n_status = sams_pkg::ST_FULL;
        end else if (r_mode == sams_pkg::MODE_POP && fill_zero) begin
            n_status = sams_pkg::ST_EMPTY;
        end else begin
            n_status = sams_pkg::ST_OK;
        end
    end

    assign n_smin = (r_cnt == '0 || r_rdata < r_smin) ? r_rdata : r_smin;

    assign o_stat.bad_id     = bad_id;
    assign o_stat.mode       = r_mode;
    assign o_stat.fill_zero  = fill_zero;
    assign o_stat.full       = full;
    assign o_stat.pop_is_min = r_pop == cur_min;
    assign o_stat.scan_last  = scan_last;
    assign o_stat.out_busy   = r_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[wr_addr] <= r_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_fill[k] <= '0;
                r_min[k]  <= 32'sd0;
            end
        end else begin
            if (i_cmd.load_out) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_fill[sidx] <= cur_fill + FW'(1);
                if (fill_zero || r_data < cur_min) begin
                    r_min[sidx] <= r_data;
                end
            end
            if (i_cmd.pop_commit) begin
                r_fill[sidx] <= fill_dec;
                if (fill_dec == '0) begin
                    r_min[sidx] <= 32'sd0;
                end
            end
            if (i_cmd.scan_step && scan_last) begin
                r_min[sidx] <= n_smin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_id   <= i_stack_id;
            r_data <= i_data;
        end
        if (i_cmd.eval) begin
            r_status <= n_status;
            r_pop    <= 32'sd0;
        end
        if (i_cmd.push) begin
            r_top <= r_data;
        end else if (i_cmd.eval) begin
            r_top <= 32'sd0;
        end
        if (i_cmd.pop_commit) begin
            r_pop <= r_rdata;
        end
        if (i_cmd.scan_start) begin
            r_cnt <= '0;
        end
        if (i_cmd.scan_step) begin
            r_smin <= n_smin;
            r_cnt  <= r_cnt + FW'(1);
            if (scan_last) begin
                r_top <= r_rdata;
            end
        end
        if (i_cmd.cap_top) begin
            r_top <= r_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_pop    <= r_pop;
            r_out_top    <= r_top;
            r_out_min    <= fill_zero ? 32'sd0 : cur_min;
            r_out_fill   <= fill_ext[8:0];
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_pop;
    assign o_top_value    = r_out_top;
    assign o_min_value    = r_out_min;
    assign o_fill_level   = r_out_fill;

endmodule

/* src/sams_ctrl.sv */
// ----------------------------------------------------------------------------
// sams_ctrl
// Sequencer: decodes one operation into memory reads, writes and a min rescan.
// ----------------------------------------------------------------------------
module sams_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sams_pkg::t_stat i_stat,
    output sams_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_POPW = 3'd2;
    localparam logic [2:0] S_POPD = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_TOPW = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                o_cmd.rd_sel = sams_pkg::RD_TOP;
                if (i_stat.bad_id) begin
                    n_state = S_DONE;
                end else begin
                    case (i_stat.mode)
                        sams_pkg::MODE_PUSH: begin
                            if (!i_stat.full) begin
                                o_cmd.push = 1'b1;
                                n_state    = S_DONE;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_TOPW;
                            end
                        end
                        sams_pkg::MODE_POP: begin
                            if (i_stat.fill_zero) begin
                                n_state = S_DONE;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_POPW;
                            end
                        end
                        default: begin
                            if (i_stat.fill_zero) begin
                                n_state = S_DONE;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_TOPW;
                            end
                        end
                    endcase
                end
            end
            S_POPW: begin
                o_cmd.pop_commit = 1'b1;
                n_state          = S_POPD;
            end
            S_POPD: begin
                if (i_stat.fill_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.pop_is_min) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_sel     = sams_pkg::RD_SCAN0;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = sams_pkg::RD_TOP;
                    n_state      = S_TOPW;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.rd_sel    = sams_pkg::RD_SCAN_NEXT;
                if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_TOPW: begin
                o_cmd.cap_top = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* test/tb_shared_array_min_stacks_unit.sv */
// ----------------------------------------------------------------------------
// tb_shared_array_min_stacks_unit
// Self-checking bench for the shared-array min stacks unit. A directed table
// covers reset state, word extremes, every mode, bad ids, empty pops and
// rescans of the minimum; random traffic and a fill-to-full burst follow.
// Every accepted request is run through a bench-side stack predictor and each
// result beat is compared field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_shared_array_min_stacks_unit;

    localparam int DEPTH       = 256;
    localparam int NUM_STACKS  = 3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_ITEMS_PER_PHASE = 140;

    localparam logic [1:0]         MODE_QUERY_ALT = 2'd3;
    localparam logic [1:0]         BAD_STACK_ID   = 2'd3;
    localparam logic signed [31:0] WORD_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX       = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_val;
        logic signed [31:0] top_val;
        logic signed [31:0] min_val;
        logic [8:0]         fill;
    } t_stack_result;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         sid;
        logic signed [31:0] data;
        logic               typed;
        t_stack_result      want;
    } t_stim_row;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [1:0]         i_mode         = sams_pkg::MODE_QUERY;
    logic [1:0]         i_stack_id     = 2'd0;
    logic signed [31:0] i_data         = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_popped_value;
    logic signed [31:0] o_top_value;
    logic signed [31:0] o_min_value;
    logic [8:0]         o_fill_level;

    logic signed [31:0] stack_mem [NUM_STACKS][DEPTH];
    int                 fill_cnt  [NUM_STACKS];
    logic signed [31:0] run_min   [NUM_STACKS];

    t_stim_row     pending_rows[$];
    t_stack_result expected_results[$];
    t_stim_row     dir_rows[$];

    int snd_idle  = 0;
    int rcv_stall = 0;
    int error_cnt = 0;
    int cycle_cnt = 0;

    shared_array_min_stacks_unit #(
        .DEPTH      (DEPTH),
        .NUM_STACKS (NUM_STACKS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_stack_id     (i_stack_id),
        .i_data         (i_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_min_value    (o_min_value),
        .o_fill_level   (o_fill_level)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_stack_result apply_stack_op(input logic [1:0] mode,
                                                     input logic [1:0] sid,
                                                     input logic signed [31:0] data);
        t_stack_result      r;
        int                 n;
        int                 i;
        logic signed [31:0] lo;
        r = '0;
        if (sid >= NUM_STACKS) begin
            r.status = sams_pkg::ST_BADID;
            return r;
        end
        n = fill_cnt[sid];
        case (mode)
            sams_pkg::MODE_PUSH: begin
                if (n >= DEPTH) begin
                    r.status = sams_pkg::ST_FULL;
                end else begin
                    stack_mem[sid][n] = data;
                    fill_cnt[sid] = n + 1;
                    if (n == 0 || data < run_min[sid]) run_min[sid] = data;
                end
            end
            sams_pkg::MODE_POP: begin
                if (n == 0) begin
                    r.status = sams_pkg::ST_EMPTY;
                end else begin
                    r.popped_val = stack_mem[sid][n - 1];
                    fill_cnt[sid] = n - 1;
                    if (n == 1) begin
                        run_min[sid] = '0;
                    end else if (r.popped_val == run_min[sid]) begin
                        lo = stack_mem[sid][0];
                        for (i = 1; i < n - 1; i++) begin
                            if (stack_mem[sid][i] < lo) lo = stack_mem[sid][i];
                        end
                        run_min[sid] = lo;
                    end
                end
            end
            default: ;
        endcase
        if (r.status != sams_pkg::ST_EMPTY) begin
            r.fill = 9'(fill_cnt[sid]);
            if (fill_cnt[sid] > 0) begin
                r.top_val = stack_mem[sid][fill_cnt[sid] - 1];
                r.min_val = run_min[sid];
            end
        end
        return r;
    endfunction

    function automatic t_stim_row mk_row(input logic [1:0] mode, input logic [1:0] sid,
                                         input logic signed [31:0] data, input logic typed,
                                         input logic [1:0] status,
                                         input logic signed [31:0] popped_val,
                                         input logic signed [31:0] top_val,
                                         input logic signed [31:0] min_val,
                                         input logic [8:0] fill);
        t_stim_row row;
        row.mode            = mode;
        row.sid             = sid;
        row.data            = data;
        row.typed           = typed;
        row.want.status     = status;
        row.want.popped_val = popped_val;
        row.want.top_val    = top_val;
        row.want.min_val    = min_val;
        row.want.fill       = fill;
        return row;
    endfunction

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(3))
            0:       return $signed($urandom_range(8)) - 4;
            1: begin
                case ($urandom_range(3))
                    0:       return WORD_MIN;
                    1:       return WORD_MAX;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_cnt++;
        end
    endtask

    task automatic send_beat(input t_stim_row row);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= row.mode;
        i_stack_id <= row.sid;
        i_data     <= row.data;
        pending_rows.push_back(row);
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [1:0] mode, input logic [1:0] sid,
                           input logic signed [31:0] data);
        send_beat(mk_row(mode, sid, data, 1'b0, sams_pkg::ST_OK, '0, '0, '0, '0));
    endtask

    task automatic send_random_op();
        logic [1:0] mode;
        logic [1:0] sid;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 45)      mode = sams_pkg::MODE_PUSH;
        else if (pick < 80) mode = sams_pkg::MODE_POP;
        else if (pick < 95) mode = sams_pkg::MODE_QUERY;
        else                mode = MODE_QUERY_ALT;
        if ($urandom_range(99) < 5) sid = BAD_STACK_ID;
        else                        sid = 2'($urandom_range(NUM_STACKS - 1));
        send_op(mode, sid, pick_word());
    endtask

    task automatic fill_then_drain(input logic [1:0] sid);
        while (fill_cnt[sid] < DEPTH) send_op(sams_pkg::MODE_PUSH, sid, pick_word());
        send_op(sams_pkg::MODE_PUSH, sid, pick_word());
        send_op(sams_pkg::MODE_PUSH, sid, WORD_MIN);
        send_op(sams_pkg::MODE_QUERY, sid, pick_word());
        while (fill_cnt[sid] > 0) send_op(sams_pkg::MODE_POP, sid, pick_word());
        send_op(sams_pkg::MODE_POP, sid, pick_word());
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** shared_array_min_stacks_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_stack_result want;
        t_stack_result got;
        t_stim_row     row;
        if (i_rst_n && i_valid && o_ready) begin
            want = apply_stack_op(i_mode, i_stack_id, i_data);
            row  = pending_rows.pop_front();
            expected_results.push_back(row.typed ? row.want : want);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                error_cnt++;
            end else begin
                got  = expected_results.pop_front();
                check_field("status", longint'(got.status), longint'(o_status));
                check_field("popped_value", longint'(got.popped_val),
                            longint'(o_popped_value));
                check_field("top_value", longint'(got.top_val), longint'(o_top_value));
                check_field("min_value", longint'(got.min_val), longint'(o_min_value));
                check_field("fill_level", longint'(got.fill), longint'(o_fill_level));
            end
        end
    end

    initial begin
        int k;
        for (k = 0; k < NUM_STACKS; k++) begin
            fill_cnt[k] = 0;
            run_min[k]  = '0;
        end

        dir_rows.push_back(mk_row(sams_pkg::MODE_QUERY, 2'd0, 32'sd9, 1'b1,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd1, -1, 1'b1,
                                  sams_pkg::ST_EMPTY, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, BAD_STACK_ID, -1, 1'b1,
                                  sams_pkg::ST_BADID, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, BAD_STACK_ID, 0, 1'b1,
                                  sams_pkg::ST_BADID, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_QUERY, BAD_STACK_ID, 0, 1'b1,
                                  sams_pkg::ST_BADID, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(MODE_QUERY_ALT, 2'd2, 7, 1'b1,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd0, WORD_MIN, 1'b1,
                                  sams_pkg::ST_OK, 0, WORD_MIN, WORD_MIN, 9'd1));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd0, WORD_MAX, 1'b1,
                                  sams_pkg::ST_OK, 0, WORD_MAX, WORD_MIN, 9'd2));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd0, 0, 1'b1,
                                  sams_pkg::ST_OK, WORD_MAX, WORD_MIN, WORD_MIN, 9'd1));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd0, 0, 1'b1,
                                  sams_pkg::ST_OK, WORD_MIN, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd0, 0, 1'b1,
                                  sams_pkg::ST_EMPTY, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd1, 5, 1'b1,
                                  sams_pkg::ST_OK, 0, 5, 5, 9'd1));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd1, -3, 1'b1,
                                  sams_pkg::ST_OK, 0, -3, -3, 9'd2));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd1, 8, 1'b1,
                                  sams_pkg::ST_OK, 0, 8, -3, 9'd3));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd1, -3, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd1, 7, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd1, 11, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd1, 0, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd1, 0, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_POP, 2'd1, 0, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(MODE_QUERY_ALT, 2'd1, -1, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd2, 0, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd2, -1, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd0, 32'sh5555_5555, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));
        dir_rows.push_back(mk_row(sams_pkg::MODE_PUSH, 2'd0, 32'shaaaa_aaaa, 1'b0,
                                  sams_pkg::ST_OK, 0, 0, 0, 9'd0));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle  = 32;
        rcv_stall = 57;
        foreach (dir_rows[k]) send_beat(dir_rows[k]);
        repeat (RANDOM_ITEMS_PER_PHASE) send_random_op();

        snd_idle  = 57;
        rcv_stall = 32;
        repeat (RANDOM_ITEMS_PER_PHASE / 2) send_random_op();
        fill_then_drain(2'($urandom_range(NUM_STACKS - 1)));
        repeat (RANDOM_ITEMS_PER_PHASE / 2) send_random_op();

        snd_idle  = 0;
        rcv_stall = 0;
        repeat (RANDOM_ITEMS_PER_PHASE) send_random_op();

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("** shared_array_min_stacks_unit: PASSED **");
        end else begin
            $display("** shared_array_min_stacks_unit: FAILED **");
        end
        $finish;
    end

endmodule
